// File: hdl/fcr_pkg.sv
// ----------------------------------------------------------------------------
// Framed motor command receiver package
// Shared types, field widths and constants for the receiver and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package fcr_pkg;

  // Configuration port geometry.
  localparam int unsigned CfgDataW = 15;
  localparam int unsigned CfgIdxW  = 1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegStraightSpeed = 1'd0;
  localparam logic [CfgIdxW-1:0] RegTurnSpeed     = 1'd1;

  // Register reset values.
  localparam logic [CfgDataW-1:0] StraightSpeedRst = 15'd100;
  localparam logic [CfgDataW-1:0] TurnSpeedRst     = 15'd50;

  // Default frame buffer depth.
  localparam int unsigned BufferDepthDefault = 64;

  // Input function codes.
  localparam logic FuncRxByte = 1'b0;
  localparam logic FuncTake   = 1'b1;

  // Framing and separator characters.
  localparam logic [7:0] ChStart = 8'h53;  // 'S'
  localparam logic [7:0] ChEnd   = 8'h45;  // 'E'
  localparam logic [7:0] ChColon = 8'h3A;  // ':'
  localparam logic [7:0] ChZero  = 8'h30;  // '0'
  localparam logic [7:0] ChNine  = 8'h39;  // '9'
  localparam logic [7:0] ChNul   = 8'h00;

  // Move command types.
  localparam logic [1:0] CmdForward  = 2'd0;
  localparam logic [1:0] CmdBackward = 2'd1;
  localparam logic [1:0] CmdLeft     = 2'd2;
  localparam logic [1:0] CmdRight    = 2'd3;

  // Response codes.
  localparam logic RespAck     = 1'b0;
  localparam logic RespInvalid = 1'b1;

  // One input item.
  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic               command_valid;
    logic [1:0]         command_type;
    logic [15:0]        command_id;
    logic signed [15:0] speed_left;
    logic signed [15:0] speed_right;
    logic               response_code;
    logic [15:0]        response_id;
  } out_item_t;

endpackage

`default_nettype wire

// File: hdl/fcr_stream_if.sv
// ----------------------------------------------------------------------------
// Framed motor command receiver stream channel
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcr_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// File: hdl/framed_motor_command_receiver.sv
// ----------------------------------------------------------------------------
// Framed motor command receiver
// Parses 'S'..'E' framed "type:id" text one byte per item and issues a move
// command or an invalid-command response when a frame closes.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                         Accepted when
//  --------  ---  ------------------------------  ---------------------------
//  in_ch     in   func, rx_byte                   in_ch.valid & in_ch.ready
//  out_ch    out  command and response fields     out_ch.valid & out_ch.ready
//  cfg       in   cfg_idx_i, cfg_wdata_i          cfg_we_i
//
// Every item is handled in the cycle it is accepted; a closing 'E' puts its
// result into the output register, visible on the next cycle. One item can be
// accepted every cycle. The input is only stalled while the output register
// holds a result that the sink does not take in that cycle. After reset the
// block is ready at once, with the speed registers at 100 and 50.
//
`default_nettype none

module framed_motor_command_receiver #(
  parameter int unsigned BufferDepth = fcr_pkg::BufferDepthDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [fcr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [fcr_pkg::CfgDataW-1:0] cfg_wdata_i,
  fcr_stream_if.sink                        in_ch,
  fcr_stream_if.source                      out_ch
);

  import fcr_pkg::*;

  localparam int unsigned LenW = $clog2(BufferDepth);
  localparam logic [LenW-1:0] LenLast = LenW'(BufferDepth - 1);

  typedef enum logic [2:0] {
    PhTypeFirst,
    PhTypeMore,
    PhIdFirst,
    PhIdMore,
    PhDone,
    PhFail
  } phase_e;

  logic [CfgDataW-1:0] straight_q, straight_d;
  logic [CfgDataW-1:0] turn_q, turn_d;
  logic                pending_q, pending_d;
  logic [LenW-1:0]     len_q, len_d;
  phase_e              phase_q, phase_d;
  logic [7:0]          type_q, type_d;
  logic [15:0]         id_q, id_d;
  logic                ended_q, ended_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;

  in_item_t            item;
  logic                accept;
  logic                is_digit;
  logic [3:0]          digit;
  logic [15:0]         s_ext, t_ext;

  // Input handshake: the output register frees up when its result is taken.
  assign in_ch.ready = ~out_valid_q | out_ch.ready;
  assign accept      = in_ch.valid & in_ch.ready;
  assign item        = in_ch.payload;

  assign out_ch.valid   = out_valid_q;
  assign out_ch.payload = out_q;

  // Digit decode of the received byte.
  always_comb begin
    is_digit = item.rx_byte inside {[ChZero:ChNine]};
    digit    = is_digit ? 4'(item.rx_byte - ChZero) : 4'd0;
  end

  assign s_ext = {1'b0, straight_q};
  assign t_ext = {1'b0, turn_q};

  // Next state, parse step and result build.
  always_comb begin
    straight_d  = straight_q;
    turn_d      = turn_q;
    pending_d   = pending_q;
    len_d       = len_q;
    phase_d     = phase_q;
    type_d      = type_q;
    id_d        = id_q;
    ended_d     = ended_q;
    out_valid_d = out_valid_q & ~out_ch.ready;
    out_d       = out_q;

    // Configuration writes.
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegStraightSpeed: straight_d = cfg_wdata_i;
        RegTurnSpeed:     turn_d     = cfg_wdata_i;
        default: ;
      endcase
    end

    if (accept) begin
      if (item.func == FuncTake) begin
        pending_d = 1'b0;
      end else if (!pending_q) begin
        if (item.rx_byte == ChStart) begin
          len_d   = '0;
          phase_d = PhTypeFirst;
          type_d  = '0;
          id_d    = '0;
          ended_d = 1'b0;
        end else if (item.rx_byte == ChEnd && len_q != '0) begin
          // Frame closes: build the one result.
          out_d = '0;
          if (phase_q == PhIdMore || phase_q == PhDone) begin
            if (type_q <= 8'd3) begin
              out_d.command_valid = 1'b1;
              out_d.command_type  = type_q[1:0];
              out_d.command_id    = id_q;
              out_d.response_code = RespAck;
              out_d.response_id   = id_q;
              case (type_q[1:0])
                CmdForward: begin
                  out_d.speed_left  = s_ext;
                  out_d.speed_right = s_ext;
                end
                CmdBackward: begin
                  out_d.speed_left  = -s_ext;
                  out_d.speed_right = -s_ext;
                end
                CmdLeft: begin
                  out_d.speed_left  = -t_ext;
                  out_d.speed_right = t_ext;
                end
                default: begin
                  out_d.speed_left  = t_ext;
                  out_d.speed_right = -t_ext;
                end
              endcase
            end else begin
              out_d.response_code = RespInvalid;
              out_d.response_id   = id_q;
            end
          end else begin
            out_d.response_code = RespInvalid;
            out_d.response_id   = '0;
          end
          out_valid_d = 1'b1;
          pending_d   = 1'b1;
          len_d       = '0;
          phase_d     = PhTypeFirst;
          type_d      = '0;
          id_d        = '0;
          ended_d     = 1'b0;
        end else if (len_q != LenLast) begin
          len_d = len_q + 1'b1;
          // Parse one character unless the text has already ended.
          if (!ended_q) begin
            if (item.rx_byte == ChNul) begin
              ended_d = 1'b1;
            end else begin
              case (phase_q)
                PhTypeFirst: begin
                  if (is_digit) begin
                    type_d  = {4'd0, digit};
                    phase_d = PhTypeMore;
                  end else begin
                    phase_d = PhFail;
                  end
                end
                PhTypeMore: begin
                  if (is_digit) begin
                    type_d = (type_q << 3) + (type_q << 1) + {4'd0, digit};
                  end else if (item.rx_byte == ChColon) begin
                    phase_d = PhIdFirst;
                  end else begin
                    phase_d = PhFail;
                  end
                end
                PhIdFirst: begin
                  if (is_digit) begin
                    id_d    = {12'd0, digit};
                    phase_d = PhIdMore;
                  end else begin
                    phase_d = PhFail;
                  end
                end
                PhIdMore: begin
                  if (is_digit) begin
                    id_d = (id_q << 3) + (id_q << 1) + {12'd0, digit};
                  end else begin
                    phase_d = PhDone;
                  end
                end
                PhDone: ;
                default: phase_d = PhFail;
              endcase
            end
          end
        end else begin
          // Buffer full: drop the byte and restart the frame.
          len_d   = '0;
          phase_d = PhTypeFirst;
          type_d  = '0;
          id_d    = '0;
          ended_d = 1'b0;
        end
      end
    end
  end

  // State and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      straight_q  <= StraightSpeedRst;
      turn_q      <= TurnSpeedRst;
      pending_q   <= 1'b0;
      len_q       <= '0;
      phase_q     <= PhTypeFirst;
      type_q      <= '0;
      id_q        <= '0;
      ended_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      straight_q  <= straight_d;
      turn_q      <= turn_d;
      pending_q   <= pending_d;
      len_q       <= len_d;
      phase_q     <= phase_d;
      type_q      <= type_d;
      id_q        <= id_d;
      ended_q     <= ended_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

endmodule

`default_nettype wire
